### src/elz_pkg.sv
// elz_pkg: shared types and constants of the escape-byte LZ decompressor
// no dependencies; imported by the top level
`default_nettype none
package elz_pkg;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_BUSY  = 3'd1;
	localparam logic [2:0] ST_BADOFF = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_TRUNC = 3'd4;

	// configuration register indexes
	localparam logic REG_ESCAPE = 1'b0;
	localparam logic REG_OUTLEN = 1'b1;

	// command constants
	localparam int LEN_BIAS   = 4;
	localparam int NO_OFFSET  = 3;
	localparam int LENHI_SHIFT = 5;

	// one result, without the last marker
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic [2:0]  status;
		logic [13:0] copy_left;
	} res_t;

endpackage
`default_nettype wire

### src/elz_if.sv
// elz_if: valid/ready channel interfaces for compressed items and results
// no dependencies
`default_nettype none
interface elz_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;
	logic       stream_end;
	modport source (output valid, mode, data_byte, stream_end, input ready);
	modport sink (input valid, mode, data_byte, stream_end, output ready);
endinterface

interface elz_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic [2:0]  status;
	logic [13:0] copy_left;
	modport source (output valid, out_byte, byte_valid, run_last, status, copy_left,
		input ready);
	modport sink (input valid, out_byte, byte_valid, run_last, status, copy_left,
		output ready);
endinterface
`default_nettype wire

### src/elz_ram.sv
// elz_ram: generic single-port synchronous ram, registered read
// no dependencies
`default_nettype none
module elz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or read, read data held otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule
`default_nettype wire

### src/escape_lz_decompressor.sv
// escape_lz_decompressor: top level, command parser, copy sequencer, apb registers
// depends on elz_pkg, elz_if (elz_in_if, elz_out_if) and elz_ram
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      mode, data_byte, stream_end
//  out_ch    out  valid/ready      out_byte, byte_valid, run_last, status, copy_left
//  apb       in   psel/penable     escape_code @0x0, output_length @0x4
//
// a literal or command byte passes through accept, drain check, then handing the
// last result to the output register; each copy byte adds a history read, then
// a write back through the single ram port.
// reset clears all control state; history contents are undefined until written.
// a stalled result output holds the sequencer; no new item is taken until all
// results of the current item are handed to the output register.
`default_nettype none
module escape_lz_decompressor #(
	parameter int HISTORY_DEPTH = 65536,
	parameter int BURST_MAX     = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	elz_in_if.sink           in_ch,
	elz_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import elz_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int KW = $clog2(BURST_MAX + 1);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

	typedef enum logic [2:0] {
		P_IDLE, P_CODE, P_LENHI, P_OFF0, P_OFF1, P_OFF2
	} phase_t;

	typedef enum logic [1:0] {S_IDLE, S_DRAIN, S_RD, S_FIN} state_t;

	state_t      state_q;
	phase_t      ph_q, ph_n;
	logic [7:0]  esc_q;
	logic [31:0] olen_q;
	logic [31:0] wc_q;
	logic [AW-1:0] wr_q, src_q;
	logic [7:0]  cmd_q, cmd_n;
	logic [13:0] len_q, len_n;
	logic [23:0] off_q, off_n;
	logic [13:0] crem_q;
	logic        pad_q;
	logic [KW-1:0] k_q;
	res_t        pend_q;
	logic        pend_v_q;
	res_t        out_q;
	logic        out_last_q, out_v_q;

	// apb registers
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_OUTLEN) ? olen_q : {24'd0, esc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= '0;
			olen_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_ESCAPE) begin
				esc_q <= pwdata[7:0];
			end else begin
				olen_q <= pwdata;
			end
		end
	end

	// command parser for one compressed byte
	logic [7:0]  b, c;
	logic        pair, lit, start, bad, trunc, full, busy;
	logic [24:0] p;
	logic [AW:0] pw, pp, src_w;
	always_comb begin
		b = in_ch.data_byte;
		c = (b > esc_q) ? b - 8'd1 : b;
		ph_n = ph_q; cmd_n = cmd_q; len_n = len_q; off_n = off_q;
		pair = 1'b0; lit = 1'b0; start = 1'b0;
		case (ph_q)
			P_IDLE: begin
				if (b == esc_q) ph_n = P_CODE;
				else lit = 1'b1;
			end
			P_CODE: begin
				if (b == esc_q) begin
					ph_n = P_IDLE; pair = 1'b1; lit = 1'b1;
				end else begin
					cmd_n = c;
					len_n = {9'd0, c[7:3]};
					off_n = '0;
					if (c[2]) ph_n = P_LENHI;
					else if (c[1:0] == 2'(NO_OFFSET)) start = 1'b1;
					else ph_n = P_OFF0;
				end
			end
			P_LENHI: begin
				len_n = len_q | ({6'd0, b} << LENHI_SHIFT);
				off_n = '0;
				if (cmd_q[1:0] == 2'(NO_OFFSET)) start = 1'b1;
				else ph_n = P_OFF0;
			end
			P_OFF0: begin
				off_n = {16'd0, b};
				if (cmd_q[1:0] == 2'd0) start = 1'b1;
				else ph_n = P_OFF1;
			end
			P_OFF1: begin
				off_n = off_q | {8'd0, b, 8'd0};
				if (cmd_q[1:0] == 2'd1) start = 1'b1;
				else ph_n = P_OFF2;
			end
			P_OFF2: begin
				off_n = off_q | {b, 16'd0};
				start = 1'b1;
			end
			default: ph_n = P_IDLE;
		endcase
		if (start) ph_n = P_IDLE;
		p   = {1'b0, off_n} + 25'd1;
		bad = start && (({7'd0, p} > wc_q) || ({7'd0, p} > 32'(HISTORY_DEPTH)));
		// copy source, wrapped into the history
		pw = {1'b0, wr_q};
		pp = p[AW:0];
		src_w = (pw >= pp) ? pw - pp : pw + DEPTH_W - pp;
		trunc = in_ch.stream_end && (ph_n != P_IDLE);
		full  = wc_q >= olen_q;
		busy  = (crem_q != '0) || pad_q;
	end

	// sequencer handshake conditions and ram control
	logic acc, can_push, can_emit, room, lit_wr, rd_go, rd_wr, pad_wr;
	logic [7:0] rdata;
	logic       ram_en, ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0] ram_wdata;
	always_comb begin
		acc      = in_ch.valid && in_ch.ready;
		can_push = !out_v_q || out_ch.ready;
		can_emit = !pend_v_q || can_push;
		room     = k_q < KW'(BURST_MAX);
		lit_wr   = acc && !in_ch.mode && !busy && lit && !full;
		rd_go    = (state_q == S_DRAIN) && room && (crem_q != '0) && !full;
		rd_wr    = (state_q == S_RD) && can_emit;
		pad_wr   = (state_q == S_DRAIN) && room && (crem_q == '0) && pad_q && !full
			&& can_emit;
		ram_en    = lit_wr || rd_go || rd_wr || pad_wr;
		ram_we    = !rd_go;
		ram_addr  = rd_go ? src_q : wr_q;
		ram_wdata = lit_wr ? b : (rd_wr ? rdata : esc_q);
	end

	elz_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (rdata)
	);

	assign in_ch.ready = (state_q == S_IDLE);

	// next write position and next copy source position
	logic [AW-1:0] wr_inc, src_inc;
	assign wr_inc  = (wr_q == LAST_ADDR) ? '0 : wr_q + AW'(1);
	assign src_inc = (src_q == LAST_ADDR) ? '0 : src_q + AW'(1);

	// state, parse registers, pending result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ph_q <= P_IDLE;
			cmd_q <= '0; len_q <= '0; off_q <= '0;
			wc_q <= '0; wr_q <= '0; src_q <= '0; crem_q <= '0;
			pad_q <= 1'b0; k_q <= '0;
			pend_v_q <= 1'b0; out_v_q <= 1'b0; out_last_q <= 1'b0;
			pend_q <= '0; out_q <= '0;
		end else begin
			if (out_ch.ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						k_q <= '0;
						state_q <= S_DRAIN;
						if (in_ch.mode) begin
							// pull only drains
						end else if (busy) begin
							pend_q <= '{8'd0, 1'b0, ST_BUSY, crem_q};
							pend_v_q <= 1'b1;
							k_q <= KW'(1);
							state_q <= S_FIN;
						end else begin
							ph_q <= ph_n; cmd_q <= cmd_n; len_q <= len_n; off_q <= off_n;
							if (lit) begin
								k_q <= KW'(1);
								pend_v_q <= 1'b1;
								if (full) begin
									pend_q <= '{8'd0, 1'b0, ST_FULL, 14'd0};
								end else begin
									pend_q <= '{b, 1'b1, ST_OK, 14'd0};
									wc_q <= wc_q + 32'd1;
									wr_q <= wr_inc;
								end
							end
							if (bad) begin
								k_q <= KW'(1);
								pend_v_q <= 1'b1;
								pend_q <= '{8'd0, 1'b0, ST_BADOFF, 14'd0};
							end else if (start) begin
								crem_q <= len_n + 14'(LEN_BIAS);
								src_q <= src_w[AW-1:0];
							end
							if (trunc) begin
								ph_q <= P_IDLE;
								k_q <= KW'(1);
								pend_v_q <= 1'b1;
								pend_q <= '{8'd0, 1'b0, ST_TRUNC, 14'd0};
							end else if (in_ch.stream_end && !pair) begin
								pad_q <= 1'b1;
							end
						end
					end
				end
				S_DRAIN: begin
					if (!room) begin
						state_q <= S_FIN;
					end else if (crem_q != '0) begin
						if (!full) begin
							state_q <= S_RD;
						end else if (can_emit) begin
							crem_q <= '0;
							pad_q <= 1'b0;
							if (pend_v_q) begin
								out_q <= pend_q; out_last_q <= 1'b0; out_v_q <= 1'b1;
							end
							pend_q <= '{8'd0, 1'b0, ST_FULL, 14'd0};
							pend_v_q <= 1'b1;
							k_q <= k_q + KW'(1);
							state_q <= S_FIN;
						end
					end else if (pad_q && !full) begin
						if (can_emit) begin
							pad_q <= 1'b0;
							wc_q <= wc_q + 32'd1;
							wr_q <= wr_inc;
							if (pend_v_q) begin
								out_q <= pend_q; out_last_q <= 1'b0; out_v_q <= 1'b1;
							end
							pend_q <= '{esc_q, 1'b1, ST_OK, 14'd0};
							pend_v_q <= 1'b1;
							k_q <= k_q + KW'(1);
							state_q <= S_FIN;
						end
					end else begin
						pad_q <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_RD: begin
					// history byte is on the ram output
					if (can_emit) begin
						crem_q <= crem_q - 14'd1;
						src_q <= src_inc;
						wc_q <= wc_q + 32'd1;
						wr_q <= wr_inc;
						if (pend_v_q) begin
							out_q <= pend_q; out_last_q <= 1'b0; out_v_q <= 1'b1;
						end
						pend_q <= '{rdata, 1'b1, ST_OK, crem_q - 14'd1};
						pend_v_q <= 1'b1;
						k_q <= k_q + KW'(1);
						state_q <= S_DRAIN;
					end
				end
				S_FIN: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (can_push) begin
						out_q <= pend_q; out_last_q <= 1'b1; out_v_q <= 1'b1;
						pend_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.out_byte   = out_q.out_byte;
	assign out_ch.byte_valid = out_q.byte_valid;
	assign out_ch.status     = out_q.status;
	assign out_ch.copy_left  = out_q.copy_left;
	assign out_ch.run_last   = out_last_q;

	// burst counter stays within the limit
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= KW'(BURST_MAX)) else $error("burst count over limit");

	// a history read only happens with copy bytes left
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> crem_q != '0) else $error("read with empty copy");

	// every result of an item is handed over before the next item
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q) else $error("result left behind");

	// a pull never changes the parse phase
	a_pull: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.mode |=> $stable(ph_q))
		else $error("pull changed parse phase");
endmodule
`default_nettype wire
